/* hdl/rle_sprite_span_scaler_macros.svh */
// assertion macros shared by the sprite span scaler modules
`ifndef RLE_SPRITE_SPAN_SCALER_MACROS_SVH
`define RLE_SPRITE_SPAN_SCALER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RSSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rsss_pkg.sv */
// types and constants of the sprite span scaler
package rsss_pkg;

	// sprite layout
	localparam logic [7:0]  ROW_COUNT   = 8'd200;
	localparam logic [16:0] TABLE_BYTES = 17'h00190;
	localparam logic [16:0] MIN_SIZE    = 17'h00192;

	// run coding
	localparam logic [7:0] SHORT_RUN_MIN  = 8'h20;
	localparam logic [7:0] ZERO_COUNT_LEN = 8'd255;
	localparam logic [4:0] CLEAR_COLOR_A  = 5'd0;
	localparam logic [4:0] CLEAR_COLOR_B  = 5'd16;
	localparam int         X_FRAC_BITS    = 8;

	// input functions
	localparam logic FUNC_LOAD = 1'b0;

	// walk phases
	localparam logic [1:0] PH_ROW  = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	// register indexes
	localparam logic [1:0] REG_CENTER_X    = 2'd0;
	localparam logic [1:0] REG_TOP_ROW     = 2'd1;
	localparam logic [1:0] REG_DRAW_HEIGHT = 2'd2;
	localparam logic [1:0] REG_SPRITE_SIZE = 2'd3;

	// arithmetic unit
	localparam int MUL_A_W  = 25;
	localparam int MUL_B_W  = 12;
	localparam int PROD_W   = 37;
	localparam int DIV_N_W  = 20;

	// divide by 200: shift right by 3, then multiply by ceil(2^22 / 25) and drop 22 bits
	localparam int          ROW_PRE_SHIFT   = 3;
	localparam int          ROW_RECIP_SHIFT = 22;
	localparam int          ROW_RECIP_W     = 18;
	localparam logic [17:0] ROW_RECIP       = 18'd167773;

	localparam logic OP_MUL    = 1'b0;
	localparam logic OP_MULDIV = 1'b1;

	typedef struct packed {
		logic               start;
		logic               op;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] result;
	} arith_rsp_t;

endpackage

/* hdl/rle_sprite_span_scaler.sv */
// run-length sprite span scaler top level: store, walk sequencer and config port
// A load transaction (func 0) writes one sprite byte and restarts the walk. A span
// request (func 1) walks to the next visible run and returns one clipped rectangle
// or done. After acceptance a request first picks where the walk resumes, then
// reads and skips each transparent run (one or two bytes each) and reads the
// returned run, whose edges take the two multiplies. At each new row it reads the
// row offset, scans the row-table entries for the row end, and runs the two
// row-position divides. The result is valid the cycle after the last step. The
// pace is set by the single read port of the sprite store and by the one shared
// multiply/divide unit, which divides by 200 with a shift and a reciprocal
// multiply. One transaction is in work at a time.
`include "rle_sprite_span_scaler_macros.svh"

module rle_sprite_span_scaler #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 768,
	parameter int STORE_BYTES   = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [14:0] address,
	input  logic [7:0]  data,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] x_first,
	output logic [10:0] x_past,
	output logic [9:0]  y_first,
	output logic [9:0]  y_past,
	output logic [4:0]  color,
	output logic        done_res
);
	import rsss_pkg::*;

	localparam int          AW          = $clog2(STORE_BYTES);
	localparam logic [16:0] STORE_LIMIT = 17'(STORE_BYTES);

	// sequencer states
	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_INIT      = 5'd1;
	localparam logic [4:0] S_ROW_CHK   = 5'd2;
	localparam logic [4:0] S_ROW_LO    = 5'd3;
	localparam logic [4:0] S_ROW_HI    = 5'd4;
	localparam logic [4:0] S_END_CHK   = 5'd5;
	localparam logic [4:0] S_END_LO    = 5'd6;
	localparam logic [4:0] S_END_HI    = 5'd7;
	localparam logic [4:0] S_ROW_EVAL  = 5'd8;
	localparam logic [4:0] S_ROW_W0    = 5'd9;
	localparam logic [4:0] S_ROW_W1    = 5'd10;
	localparam logic [4:0] S_ROW_XP    = 5'd11;
	localparam logic [4:0] S_RUN_CHK   = 5'd12;
	localparam logic [4:0] S_RUN_CMD   = 5'd13;
	localparam logic [4:0] S_RUN_CNT   = 5'd14;
	localparam logic [4:0] S_RUN_ADV   = 5'd15;
	localparam logic [4:0] S_RUN_W0    = 5'd16;
	localparam logic [4:0] S_RUN_W1    = 5'd17;
	localparam logic [4:0] S_EMIT_DONE = 5'd18;

	// configuration registers
	logic [12:0] center_x_q;
	logic [12:0] top_row_q;
	logic [11:0] draw_height_q;
	logic [15:0] sprite_size_q;

	// walk state
	logic [4:0]  state_q;
	logic [1:0]  phase_q;
	logic [7:0]  row_q;
	logic [15:0] byte_q;
	logic [15:0] row_end_q;
	logic [23:0] run_pos_q;

	// working registers
	logic [15:0]        start_q;
	logic [7:0]         lo_q;
	logic [7:0]         scan_q;
	logic signed [14:0] sy_q;
	logic signed [14:0] sye_q;
	logic signed [31:0] xs_q;
	logic [23:0]        xp_q;
	logic [7:0]         len_q;
	logic [4:0]         color_q;

	// output register
	logic        out_valid_q;
	logic [10:0] x_first_q;
	logic [10:0] x_past_q;
	logic [9:0]  y_first_q;
	logic [9:0]  y_past_q;
	logic [4:0]  color_out_q;
	logic        done_q;

	// store and arithmetic unit
	logic [7:0]   rdata;
	logic [16:0]  raddr_w;
	logic         we_w;
	arith_req_t   req;
	arith_rsp_t   rsp;

	// derived values
	logic [16:0]        size_cap_w;
	logic [15:0]        plen_w;
	logic               short_w;
	logic [13:0]        dh3_w;
	logic [11:0]        dw_w;
	logic signed [13:0] left_w;
	logic signed [14:0] row_pos_w;
	logic signed [31:0] x_pos_w;
	logic signed [31:0] xe_w;
	logic [15:0]        word_w;
	logic               in_fire;
	logic               cfg_write;
	logic               unit_wait_w;
	logic               emit_w;

	function automatic logic [31:0] clamp_to(input logic signed [31:0] v,
		input logic signed [31:0] hi);
		logic [31:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign in_fire   = in_valid && in_ready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign pready    = 1'b1;

	// sprite size, data length and scaled width
	assign size_cap_w = ({1'b0, sprite_size_q} >= STORE_LIMIT) ? STORE_LIMIT
		: {1'b0, sprite_size_q};
	assign short_w    = size_cap_w < MIN_SIZE;
	assign plen_w     = 16'(size_cap_w - TABLE_BYTES);
	assign dh3_w      = {1'b0, draw_height_q, 1'b0} + {2'b00, draw_height_q};
	assign dw_w       = dh3_w[13:2];
	assign left_w     = $signed({center_x_q[12], center_x_q})
		- $signed({3'b000, dw_w[11:1]});

	// positions from the arithmetic unit result
	assign row_pos_w = $signed({{2{top_row_q[12]}}, top_row_q})
		+ $signed({3'b000, rsp.result[11:0]});
	assign x_pos_w   = 32'(left_w) + $signed({3'b000, rsp.result[PROD_W-1:X_FRAC_BITS]});
	assign xe_w      = (x_pos_w <= xs_q) ? xs_q + 32'sd1 : x_pos_w;
	assign word_w    = {rdata, lo_q};

	// store read address by state
	always_comb begin
		raddr_w = '0;
		unique case (state_q)
			S_ROW_CHK: raddr_w = {8'b0, row_q, 1'b0};
			S_ROW_LO:  raddr_w = {8'b0, row_q, 1'b1};
			S_END_CHK: raddr_w = {8'b0, scan_q, 1'b0};
			S_END_LO:  raddr_w = {8'b0, scan_q, 1'b1};
			S_ROW_W1:  raddr_w = TABLE_BYTES + {1'b0, start_q};
			S_RUN_CHK: raddr_w = TABLE_BYTES + {1'b0, byte_q};
			S_RUN_CMD: raddr_w = TABLE_BYTES + {1'b0, byte_q} + 17'd1;
			default:   raddr_w = '0;
		endcase
	end

	// store write on a load transaction
	assign we_w = in_fire && (func == FUNC_LOAD) && ({2'b00, address} < STORE_LIMIT);

	rsss_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we_w),
		.waddr(AW'({2'b00, address})),
		.wdata(data),
		.raddr(raddr_w[AW-1:0]),
		.rdata(rdata)
	);

	// requests to the shared arithmetic unit
	always_comb begin
		req = '0;
		case (state_q)
			S_ROW_EVAL: begin
				if (!(start_q >= plen_w || start_q == row_end_q)) begin
					req.start = 1'b1;
					req.op    = OP_MULDIV;
					req.a     = MUL_A_W'(row_q);
					req.b     = draw_height_q;
				end
			end
			S_ROW_W0: begin
				req.start = rsp.done;
				req.op    = OP_MULDIV;
				req.a     = MUL_A_W'(row_q) + MUL_A_W'(1);
				req.b     = draw_height_q;
			end
			S_RUN_ADV: begin
				req.start = (color_q != CLEAR_COLOR_A) && (color_q != CLEAR_COLOR_B);
				req.op    = OP_MUL;
				req.a     = MUL_A_W'(run_pos_q);
				req.b     = dw_w;
			end
			S_RUN_W0: begin
				req.start = rsp.done;
				req.op    = OP_MUL;
				req.a     = MUL_A_W'(xp_q) + MUL_A_W'(len_q);
				req.b     = dw_w;
			end
			default: req = '0;
		endcase
	end

	rsss_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_CENTER_X:    prdata = {19'b0, center_x_q};
			REG_TOP_ROW:     prdata = {19'b0, top_row_q};
			REG_DRAW_HEIGHT: prdata = {20'b0, draw_height_q};
			REG_SPRITE_SIZE: prdata = {16'b0, sprite_size_q};
			default:         prdata = '0;
		endcase
	end

	// walk sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			top_row_q     <= '0;
			draw_height_q <= '0;
			sprite_size_q <= '0;
			state_q       <= S_IDLE;
			phase_q       <= PH_ROW;
			row_q         <= '0;
			byte_q        <= '0;
			row_end_q     <= '0;
			run_pos_q     <= '0;
			start_q       <= '0;
			lo_q          <= '0;
			scan_q        <= '0;
			sy_q          <= '0;
			sye_q         <= '0;
			xs_q          <= '0;
			xp_q          <= '0;
			len_q         <= '0;
			color_q       <= '0;
			out_valid_q   <= 1'b0;
			x_first_q     <= '0;
			x_past_q      <= '0;
			y_first_q     <= '0;
			y_past_q      <= '0;
			color_out_q   <= '0;
			done_q        <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (func == FUNC_LOAD) begin
							row_q     <= '0;
							byte_q    <= '0;
							row_end_q <= '0;
							run_pos_q <= '0;
							phase_q   <= PH_ROW;
						end else begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					if (short_w || phase_q == PH_DONE) begin
						phase_q <= PH_DONE;
						state_q <= S_EMIT_DONE;
					end else if (phase_q == PH_RUN) begin
						state_q <= S_RUN_CHK;
					end else begin
						state_q <= S_ROW_CHK;
					end
				end
				S_ROW_CHK: begin
					if (row_q >= ROW_COUNT) begin
						phase_q <= PH_DONE;
						state_q <= S_EMIT_DONE;
					end else begin
						state_q <= S_ROW_LO;
					end
				end
				S_ROW_LO: begin
					lo_q    <= rdata;
					state_q <= S_ROW_HI;
				end
				S_ROW_HI: begin
					start_q <= word_w;
					scan_q  <= row_q + 8'd1;
					state_q <= S_END_CHK;
				end
				S_END_CHK: begin
					if (scan_q >= ROW_COUNT) begin
						row_end_q <= plen_w;
						state_q   <= S_ROW_EVAL;
					end else begin
						state_q <= S_END_LO;
					end
				end
				S_END_LO: begin
					lo_q    <= rdata;
					state_q <= S_END_HI;
				end
				S_END_HI: begin
					if (word_w != start_q) begin
						row_end_q <= word_w;
						state_q   <= S_ROW_EVAL;
					end else begin
						scan_q  <= scan_q + 8'd1;
						state_q <= S_END_CHK;
					end
				end
				S_ROW_EVAL: begin
					// empty rows and rows past the data are skipped
					if (start_q >= plen_w || start_q == row_end_q) begin
						row_q   <= row_q + 8'd1;
						state_q <= S_ROW_CHK;
					end else begin
						state_q <= S_ROW_W0;
					end
				end
				S_ROW_W0: begin
					if (rsp.done) begin
						sy_q    <= row_pos_w;
						state_q <= S_ROW_W1;
					end
				end
				S_ROW_W1: begin
					if (rsp.done) begin
						sye_q <= row_pos_w;
						if (32'(sy_q) >= SCREEN_HEIGHT) begin
							phase_q <= PH_DONE;
							state_q <= S_EMIT_DONE;
						end else if (row_pos_w <= 15'sd0) begin
							row_q   <= row_q + 8'd1;
							state_q <= S_ROW_CHK;
						end else begin
							state_q <= S_ROW_XP;
						end
					end
				end
				S_ROW_XP: begin
					run_pos_q <= {16'b0, rdata};
					byte_q    <= start_q + 16'd1;
					phase_q   <= PH_RUN;
					state_q   <= S_RUN_CHK;
				end
				S_RUN_CHK: begin
					if (!(byte_q < row_end_q && byte_q < plen_w)) begin
						phase_q <= PH_ROW;
						row_q   <= row_q + 8'd1;
						state_q <= S_ROW_CHK;
					end else begin
						state_q <= S_RUN_CMD;
					end
				end
				S_RUN_CMD: begin
					color_q <= rdata[4:0];
					if (rdata >= SHORT_RUN_MIN) begin
						len_q   <= {5'b0, rdata[7:5]};
						byte_q  <= byte_q + 16'd1;
						state_q <= S_RUN_ADV;
					end else if (byte_q + 16'd1 >= plen_w) begin
						// count byte cut off by the data end
						phase_q <= PH_ROW;
						row_q   <= row_q + 8'd1;
						state_q <= S_ROW_CHK;
					end else begin
						byte_q  <= byte_q + 16'd1;
						state_q <= S_RUN_CNT;
					end
				end
				S_RUN_CNT: begin
					len_q   <= (rdata == 8'd0) ? ZERO_COUNT_LEN : rdata;
					byte_q  <= byte_q + 16'd1;
					state_q <= S_RUN_ADV;
				end
				S_RUN_ADV: begin
					xp_q      <= run_pos_q;
					run_pos_q <= run_pos_q + 24'(len_q);
					if (color_q == CLEAR_COLOR_A || color_q == CLEAR_COLOR_B) begin
						state_q <= S_RUN_CHK;
					end else begin
						state_q <= S_RUN_W0;
					end
				end
				S_RUN_W0: begin
					if (rsp.done) begin
						xs_q    <= x_pos_w;
						state_q <= S_RUN_W1;
					end
				end
				S_RUN_W1: begin
					if (rsp.done) begin
						x_first_q   <= 11'(clamp_to(xs_q, SCREEN_WIDTH));
						x_past_q    <= 11'(clamp_to(xe_w, SCREEN_WIDTH));
						y_first_q   <= 10'(clamp_to(32'(sy_q), SCREEN_HEIGHT));
						y_past_q    <= 10'(clamp_to(32'(sye_q), SCREEN_HEIGHT));
						color_out_q <= color_q;
						done_q      <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_EMIT_DONE: begin
					x_first_q   <= '0;
					x_past_q    <= '0;
					y_first_q   <= '0;
					y_past_q    <= '0;
					color_out_q <= '0;
					done_q      <= 1'b1;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// register write restarts the walk
			if (cfg_write) begin
				unique case (paddr[3:2])
					REG_CENTER_X:    center_x_q    <= pwdata[12:0];
					REG_TOP_ROW:     top_row_q     <= pwdata[12:0];
					REG_DRAW_HEIGHT: draw_height_q <= pwdata[11:0];
					REG_SPRITE_SIZE: sprite_size_q <= pwdata[15:0];
					default:         center_x_q    <= center_x_q;
				endcase
				row_q     <= '0;
				byte_q    <= '0;
				row_end_q <= '0;
				run_pos_q <= '0;
				phase_q   <= PH_ROW;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign x_first   = x_first_q;
	assign x_past    = x_past_q;
	assign y_first   = y_first_q;
	assign y_past    = y_past_q;
	assign color     = color_out_q;
	assign done_res  = done_q;

	// states that wait on the arithmetic unit, and the cycles that load a result
	assign unit_wait_w = (state_q == S_ROW_W0) || (state_q == S_ROW_W1)
		|| (state_q == S_RUN_W0) || (state_q == S_RUN_W1);
	assign emit_w      = (state_q == S_EMIT_DONE) || (state_q == S_RUN_W1 && rsp.done);

	`RSSS_ASSERT_IMPL(a_ready_idle, state_q != S_IDLE, !in_ready, "ready while walking")
	`RSSS_ASSERT_IMPL(a_done_wait, rsp.done, unit_wait_w, "unit result outside a wait state")
	`RSSS_ASSERT_IMPL(a_emit_free, emit_w, !out_valid_q, "result overwrites a pending transaction")

endmodule

/* hdl/rsss_ram.sv */
// generic single-write, single-read ram with registered read
module rsss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/rsss_arith.sv */
// shared multiplier with a reciprocal divide-by-200 stage
`include "rle_sprite_span_scaler_macros.svh"

module rsss_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  rsss_pkg::arith_req_t req,
	output rsss_pkg::arith_rsp_t rsp
);
	import rsss_pkg::*;

	localparam int NUM_W  = DIV_N_W - ROW_PRE_SHIFT;
	localparam int QPROD_W = NUM_W + ROW_RECIP_W;

	logic                busy_q;
	logic                done_q;
	logic [DIV_N_W-1:0]  num_q;
	logic [PROD_W-1:0]   res_q;

	logic [PROD_W-1:0]   prod_w;
	logic [QPROD_W-1:0]  qprod_w;
	logic                mul_start_w;
	logic                div_start_w;

	// product of the request operands
	assign prod_w = PROD_W'(req.a) * PROD_W'(req.b);

	// quotient by 200 of the held product, exact for products below 2^20
	assign qprod_w = QPROD_W'(num_q[DIV_N_W-1:ROW_PRE_SHIFT]) * QPROD_W'(ROW_RECIP);

	assign mul_start_w = !busy_q && req.start && (req.op == OP_MUL);
	assign div_start_w = !busy_q && req.start && (req.op == OP_MULDIV);

	// a multiply registers the product; a multiply then divide holds the product, then registers its quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			num_q  <= '0;
			res_q  <= '0;
		end else begin
			busy_q <= div_start_w;
			done_q <= busy_q || mul_start_w;
			if (busy_q) begin
				res_q <= PROD_W'(qprod_w[QPROD_W-1:ROW_RECIP_SHIFT]);
			end else if (mul_start_w) begin
				res_q <= prod_w;
			end
			if (div_start_w) begin
				num_q <= prod_w[DIV_N_W-1:0];
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

	`RSSS_ASSERT_IMPL(a_no_start_busy, req.start, !busy_q, "request while divide in flight")
	`RSSS_ASSERT_NEXT(a_mul_done, mul_start_w, done_q && !busy_q, "multiply did not finish")
	`RSSS_ASSERT_NEXT(a_last_step, busy_q, done_q && !busy_q, "divide did not finish")

endmodule

/* bench/rle_sprite_span_scaler_test.sv */
// testbench of the run-length sprite span scaler: directed and random span walks
module rle_sprite_span_scaler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rsss_pkg::*;

	localparam int SCR_W = 1024;
	localparam int SCR_H = 768;
	localparam int STORE = 32768;
	localparam int IDLE_LIMIT = 400000;

	typedef struct packed {
		logic [10:0] xf;
		logic [10:0] xp;
		logic [9:0]  yf;
		logic [9:0]  yp;
		logic [4:0]  col;
		logic        dn;
	} span_t;

	localparam span_t DONE_SPAN =
		'{xf: 11'd0, xp: 11'd0, yf: 10'd0, yp: 10'd0, col: 5'd0, dn: 1'b1};

	typedef struct {
		bit          is_cfg;
		bit          fn;
		logic [14:0] addr;
		logic [31:0] val;
		bit          typed;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [14:0] address = '0;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] x_first, x_past;
	logic [9:0]  y_first, y_past;
	logic [4:0]  color;
	logic        done_res;

	rle_sprite_span_scaler u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .address(address), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_first(x_first), .x_past(x_past), .y_first(y_first), .y_past(y_past),
		.color(color), .done_res(done_res)
	);

	always #4 clk = ~clk;

	// predictor state: store, settings and walk position
	bit   [7:0]  mem [STORE];
	bit          loaded [STORE];
	bit   [7:0]  img [STORE];
	logic [12:0] cfg_cx = '0, cfg_top = '0;
	logic [11:0] cfg_dh = '0;
	logic [15:0] cfg_size = '0;
	int          w_row, w_byte, w_end;
	logic [23:0] w_xpos;
	logic [1:0]  w_phase = PH_ROW;

	span_t span_queue[$];
	int    mismatches = 0;
	int    idle_cycles = 0;
	int    burst_left = 0;
	int    rdy_left = 0;
	bit    rdy_free = 1'b1;
	bit    last_done;
	dir_row_t directed_rows[$];

	function automatic void walk_restart();
		w_row = 0;
		w_byte = 0;
		w_end = 0;
		w_xpos = '0;
		w_phase = PH_ROW;
	endfunction

	function automatic int rd(int a);
		return (a < STORE) ? int'(mem[a]) : 0;
	endfunction

	function automatic int row_offset(int r);
		return rd(2 * r) | (rd(2 * r + 1) << 8);
	endfunction

	function automatic longint clampv(longint v, longint hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	// next span of the walk, or nothing for a load
	function automatic void span_predict(input bit fn, input logic [14:0] a, input logic [7:0] d,
			output bit has_res, output span_t res);
		int size, plen, start, stop, p, cmd, len, colr, n;
		int unsigned xpos;
		longint dh, dw, left, top, sy, sye, xs, xe;
		has_res = 1'b0;
		res = '0;
		if (fn == FUNC_LOAD) begin
			mem[a] = d;
			walk_restart();
			return;
		end
		has_res = 1'b1;
		size = (int'(cfg_size) < STORE) ? int'(cfg_size) : STORE;
		if (size < int'(MIN_SIZE)) w_phase = PH_DONE;
		plen = size - int'(TABLE_BYTES);
		dh = longint'(cfg_dh);
		dw = dh * 3 / 4;
		left = longint'($signed(cfg_cx)) - dw / 2;
		top = longint'($signed(cfg_top));
		while (w_phase != PH_DONE) begin
			if (w_phase == PH_ROW) begin
				if (w_row >= 200) begin
					w_phase = PH_DONE;
					break;
				end
				start = row_offset(w_row);
				stop = plen;
				for (int j = w_row + 1; j < 200; j++) begin
					if (row_offset(j) != start) begin
						stop = row_offset(j);
						break;
					end
				end
				if (start >= plen || start == stop) begin
					w_row++;
					continue;
				end
				sy = top + longint'(w_row) * dh / 200;
				sye = top + (longint'(w_row) + 1) * dh / 200;
				if (sy >= SCR_H) begin
					w_phase = PH_DONE;
					break;
				end
				if (sye <= 0) begin
					w_row++;
					continue;
				end
				w_xpos = 24'(rd(int'(TABLE_BYTES) + start));
				w_byte = start + 1;
				w_end = stop;
				w_phase = PH_RUN;
			end else begin
				p = w_byte;
				if (!(p < w_end && p < plen)) begin
					w_phase = PH_ROW;
					w_row++;
					continue;
				end
				cmd = rd(int'(TABLE_BYTES) + p);
				p++;
				if (cmd >= int'(SHORT_RUN_MIN)) begin
					len = cmd >> 5;
					colr = cmd & 31;
				end else begin
					colr = cmd;
					// count byte cut off by the data end
					if (p >= plen) begin
						w_phase = PH_ROW;
						w_row++;
						continue;
					end
					n = rd(int'(TABLE_BYTES) + p);
					p++;
					len = (n != 0) ? n : int'(ZERO_COUNT_LEN);
				end
				w_byte = p;
				xpos = w_xpos;
				w_xpos = w_xpos + 24'(len);
				if (colr != int'(CLEAR_COLOR_A) && colr != int'(CLEAR_COLOR_B)) begin
					xs = left + longint'(xpos) * dw / 256;
					xe = left + (longint'(xpos) + len) * dw / 256;
					sy = top + longint'(w_row) * dh / 200;
					sye = top + (longint'(w_row) + 1) * dh / 200;
					if (xe <= xs) xe = xs + 1;
					res.xf = 11'(clampv(xs, SCR_W));
					res.xp = 11'(clampv(xe, SCR_W));
					res.yf = 10'(clampv(sy, SCR_H));
					res.yp = 10'(clampv(sye, SCR_H));
					res.col = 5'(colr);
					res.dn = 1'b0;
					return;
				end
			end
		end
		res = DONE_SPAN;
	endfunction

	// one input transaction, sent in bursts with gaps
	task automatic send_txn(input bit fn, input logic [14:0] a, input logic [7:0] d,
			input bit typed);
		bit has;
		span_t res;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
		end
		in_valid = 1'b1;
		func = fn;
		address = a;
		data = d;
		// ready is sampled at the rising edge that would accept
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		span_predict(fn, a, d, has, res);
		if (has) begin
			span_queue.push_back(typed ? DONE_SPAN : res);
			last_done = res.dn;
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// wait for every expected span, then let the block settle
	task automatic drain();
		in_valid = 1'b0;
		while (span_queue.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		drain();
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: cfg_cx = val[12:0];
			REG_TOP_ROW: cfg_top = val[12:0];
			REG_DRAW_HEIGHT: cfg_dh = val[11:0];
			default: cfg_size = val[15:0];
		endcase
		walk_restart();
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// load the image bytes that differ from the store or were never loaded
	task automatic load_image(input int nbytes);
		for (int i = 0; i < nbytes; i++) begin
			if (!loaded[i] || mem[i] != img[i]) begin
				send_txn(FUNC_LOAD, 15'(i), img[i], 1'b0);
				loaded[i] = 1'b1;
			end
		end
	endtask

	task automatic set_view(input int cx, input int top, input int dh);
		reg_write(REG_CENTER_X, 32'(cx) & 32'h1FFF);
		reg_write(REG_TOP_ROW, 32'(top) & 32'h1FFF);
		reg_write(REG_DRAW_HEIGHT, 32'(dh));
	endtask

	// request spans until the walk ends or max_req is reached, with an occasional stray load when noise is set
	task automatic run_walk(input int max_req, input bit noise);
		int n;
		int a;
		n = 0;
		last_done = 1'b0;
		while (n < max_req) begin
			if (noise && $urandom_range(0, 24) == 0) begin
				a = $urandom_range(0, STORE - 1);
				send_txn(FUNC_LOAD, 15'(a), 8'($urandom_range(0, 255)), 1'b0);
				loaded[a] = 1'b1;
			end else begin
				send_txn(~FUNC_LOAD, '0, 8'($urandom_range(0, 255)), 1'b0);
				n++;
				if (last_done) begin
					send_txn(~FUNC_LOAD, 15'($urandom_range(0, STORE - 1)), '0, 1'b0);
					break;
				end
			end
		end
	endtask

	// new pixel data and a few new row offsets, some past the data end
	task automatic random_image(input int plen);
		int off, i, k, r;
		for (int m = 0; m < 8; m++) begin
			r = $urandom_range(0, 199);
			off = $urandom_range(0, plen + 5);
			img[2 * r] = off[7:0];
			img[2 * r + 1] = off[15:8];
		end
		i = 0;
		while (i < plen) begin
			k = $urandom_range(0, 9);
			if (k < 4) begin
				img[400 + i] = 8'($urandom_range(32, 255));
			end else if (k < 7) begin
				img[400 + i] = 8'($urandom_range(0, 31));
				if (i + 1 < plen) begin
					i++;
					img[400 + i] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
				end
			end else begin
				img[400 + i] = 8'($urandom_range(0, 255));
			end
			i++;
		end
	endtask

	// receiver stall pattern: free stretches and choppy stretches
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_free = ($urandom_range(0, 2) == 0);
			rdy_left = $urandom_range(20, 300);
		end
		rdy_left--;
		out_ready <= rdy_free ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	// output check and idle watchdog
	always @(posedge clk) begin
		span_t got, want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("rle_sprite_span_scaler_test: done, errors");
				$finish;
			end
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{xf: x_first, xp: x_past, yf: y_first, yp: y_past, col: color, dn: done_res};
			if (span_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected span transaction %h", got);
			end else begin
				want = span_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"span mismatch: exp x %0d..%0d y %0d..%0d c %0d d %0d,",
							" got x %0d..%0d y %0d..%0d c %0d d %0d"},
							want.xf, want.xp, want.yf, want.yp, want.col, want.dn,
							got.xf, got.xp, got.yf, got.yp, got.col, got.dn);
				end
			end
		end
	end

	initial begin
		dir_row_t row;
		int plen;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		walk_restart();

		// directed: short sizes give only done
		directed_rows.push_back('{0, 1, 15'd0, 32'd0, 1});
		directed_rows.push_back('{0, 0, 15'h7FFF, 32'hFF, 0});
		directed_rows.push_back('{0, 0, 15'd0, 32'h00, 0});
		directed_rows.push_back('{0, 1, 15'h7FFF, 32'hFF, 1});
		directed_rows.push_back('{1, 0, 15'(REG_SPRITE_SIZE), 32'h191, 0});
		directed_rows.push_back('{0, 1, 15'd0, 32'd0, 1});
		directed_rows.push_back('{0, 1, 15'd0, 32'd0, 1});
		directed_rows.push_back('{1, 0, 15'(REG_CENTER_X), 32'h1000, 0});
		directed_rows.push_back('{1, 0, 15'(REG_TOP_ROW), 32'h0FFF, 0});
		directed_rows.push_back('{1, 0, 15'(REG_DRAW_HEIGHT), 32'hFFF, 0});
		directed_rows.push_back('{0, 1, 15'd0, 32'd0, 1});
		directed_rows.push_back('{1, 0, 15'(REG_SPRITE_SIZE), 32'd0, 0});
		directed_rows.push_back('{0, 1, 15'h4000, 32'h80, 1});
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) reg_write(row.addr[1:0], row.val);
			else send_txn(row.fn, row.addr, row.val[7:0], row.typed);
		end

		// crafted sprite: all run codings, transparent colors, cut-off count, rows past end
		for (int r = 0; r < 200; r++) begin
			plen = (r < 50) ? 0 : (r < 100) ? 14 : (r < 150) ? 20 : 30;
			img[2 * r] = plen[7:0];
			img[2 * r + 1] = plen[15:8];
		end
		{img[400], img[401], img[402], img[403], img[404], img[405], img[406]} =
			{8'd10, 8'h45, 8'h40, 8'h50, 8'h07, 8'h00, 8'h03};
		{img[407], img[408], img[409], img[410], img[411], img[412], img[413]} =
			{8'h05, 8'hFF, 8'h10, 8'h04, 8'h1F, 8'h80, 8'h21};
		{img[414], img[415], img[416], img[417], img[418], img[419], img[420], img[421]} =
			{8'd250, 8'h07, 8'h00, 8'hE1, 8'h20, 8'h3E, 8'd0, 8'h09};
		load_image(422);
		reg_write(REG_SPRITE_SIZE, 32'd422);
		set_view(512, 100, 400);
		run_walk(24, 0);
		set_view(-4096, -20, 4095);
		run_walk(24, 0);
		set_view(4095, 700, 4095);
		run_walk(24, 0);
		set_view(300, 0, 0);
		run_walk(24, 0);
		set_view(100, -4096, 600);
		run_walk(10, 0);

		// oversized sprite with the top below the screen: only the row table is read
		set_view(0, 4095, 200);
		reg_write(REG_SPRITE_SIZE, 32'h8000);
		run_walk(3, 0);
		reg_write(REG_SPRITE_SIZE, 32'hFFFF);
		run_walk(3, 0);

		// random sprites under random views
		for (int s = 0; s < 2; s++) begin
			plen = $urandom_range(4, 90);
			random_image(plen);
			load_image(400 + plen);
			reg_write(REG_SPRITE_SIZE, 32'(400 + plen - $urandom_range(0, 2)));
			for (int v = 0; v < 2; v++) begin
				set_view($urandom_range(0, 8191) - 4096,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) - 4096
						: $urandom_range(0, 300) - 100,
					($urandom_range(0, 4) == 0) ? 4095 : $urandom_range(0, 900));
				run_walk(24, 1);
			end
		end

		drain();
		if (mismatches == 0)
			$display("rle_sprite_span_scaler_test: done, clean");
		else
			$display("rle_sprite_span_scaler_test: done, errors");
		$finish;
	end

endmodule
